### sv/htc_pkg.sv
// shared types, register codes and reset values for the hysteresis thermostat
package htc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TEMP_W     = 8;
  localparam int HYST_W     = 7;
  localparam int LOCK_W     = 16;
  // sign-extended width for setpoint plus or minus the band
  localparam int CMP_W      = 10;

  localparam logic signed [TEMP_W-1:0] DEFAULT_SET_POINT = 8'sd20;
  localparam logic signed [TEMP_W-1:0] RST_INIT_SP       = 8'sd20;
  localparam logic [HYST_W-1:0]        RST_HYST          = 7'd3;
  localparam logic signed [TEMP_W-1:0] RST_SET_MIN       = 8'sd5;
  localparam logic signed [TEMP_W-1:0] RST_SET_MAX       = 8'sd35;
  localparam logic [LOCK_W-1:0]        RST_LOCKOUT       = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_SP = 3'd0,
    REG_HYST    = 3'd1,
    REG_SET_MIN = 3'd2,
    REG_SET_MAX = 3'd3,
    REG_LOCKOUT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_UP     = 2'd1,
    FUNC_DOWN   = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] init_sp;
    logic [HYST_W-1:0]        hyst;
    logic signed [TEMP_W-1:0] set_min;
    logic signed [TEMP_W-1:0] set_max;
    logic [LOCK_W-1:0]        lockout;
  } cfg_t;

  typedef struct packed {
    logic                     load;
    logic signed [TEMP_W-1:0] value;
  } sp_load_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [TEMP_W-1:0] set_point;
  } status_t;

endpackage

### sv/htc_cfg_regs.sv
// configuration registers and setpoint reload on initial setpoint writes
module htc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr,
  input  logic [htc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [htc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output htc_pkg::cfg_t                      cfg,
  output htc_pkg::sp_load_t                  sp_load
);

  htc_pkg::cfg_t cfg_r;
  htc_pkg::cfg_t cfg_nxt;
  logic signed [htc_pkg::TEMP_W-1:0] wr_sp;

  assign wr_sp = $signed(cfg_data[htc_pkg::TEMP_W-1:0]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        htc_pkg::REG_INIT_SP: cfg_nxt.init_sp = wr_sp;
        htc_pkg::REG_HYST:    cfg_nxt.hyst    = cfg_data[htc_pkg::HYST_W-1:0];
        htc_pkg::REG_SET_MIN: cfg_nxt.set_min = wr_sp;
        htc_pkg::REG_SET_MAX: cfg_nxt.set_max = wr_sp;
        htc_pkg::REG_LOCKOUT: cfg_nxt.lockout = cfg_data[htc_pkg::LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // reload target, checked against the limits as they stand now
  always_comb begin
    sp_load.load  = cfg_wr && (cfg_index == htc_pkg::REG_INIT_SP);
    sp_load.value = (wr_sp < cfg_r.set_max && wr_sp > cfg_r.set_min) ?
                    wr_sp : htc_pkg::DEFAULT_SET_POINT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_sp <= htc_pkg::RST_INIT_SP;
      cfg_r.hyst    <= htc_pkg::RST_HYST;
      cfg_r.set_min <= htc_pkg::RST_SET_MIN;
      cfg_r.set_max <= htc_pkg::RST_SET_MAX;
      cfg_r.lockout <= htc_pkg::RST_LOCKOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/htc_ctrl.sv
// thermostat state: mode, setpoint and button lockout, one request per step
module htc_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  htc_pkg::func_t                    func,
  input  logic signed [htc_pkg::TEMP_W-1:0] temperature,
  input  htc_pkg::cfg_t                     cfg,
  input  htc_pkg::sp_load_t                 sp_load,
  output htc_pkg::status_t                  status_nxt
);

  htc_pkg::mode_t                    mode_r, mode_nxt;
  logic signed [htc_pkg::TEMP_W-1:0] target_r, target_nxt;
  logic                              locked_r, locked_nxt;
  logic [htc_pkg::LOCK_W-1:0]        lock_count_r, lock_count_nxt;

  logic signed [htc_pkg::CMP_W-1:0]  temp_w, tgt_w, hyst_w, band_lo, band_hi;

  assign temp_w  = htc_pkg::CMP_W'(temperature);
  assign tgt_w   = htc_pkg::CMP_W'(target_r);
  assign hyst_w  = $signed({{(htc_pkg::CMP_W-htc_pkg::HYST_W){1'b0}}, cfg.hyst});
  assign band_lo = tgt_w - hyst_w;
  assign band_hi = tgt_w + hyst_w;

  always_comb begin
    mode_nxt       = mode_r;
    target_nxt     = target_r;
    locked_nxt     = locked_r;
    lock_count_nxt = lock_count_r;
    if (sp_load.load) begin
      target_nxt = sp_load.value;
    end else if (step_en) begin
      case (func) inside
        htc_pkg::FUNC_SAMPLE: begin
          case (mode_r)
            htc_pkg::MODE_OFF: begin
              if (temp_w < band_lo) begin
                mode_nxt = htc_pkg::MODE_HEAT;
              end else if (temp_w > band_hi) begin
                mode_nxt = htc_pkg::MODE_COOL;
              end
            end
            htc_pkg::MODE_HEAT: begin
              if (temperature >= target_r) mode_nxt = htc_pkg::MODE_OFF;
            end
            default: begin
              if (temperature <= target_r) mode_nxt = htc_pkg::MODE_OFF;
            end
          endcase
        end
        htc_pkg::FUNC_UP, htc_pkg::FUNC_DOWN: begin
          // presses during lockout are dropped and do not restart it
          if (!locked_r) begin
            if (func == htc_pkg::FUNC_UP) begin
              if (target_r < cfg.set_max) target_nxt = target_r + 8'sd1;
            end else begin
              if (target_r > cfg.set_min) target_nxt = target_r - 8'sd1;
            end
            locked_nxt     = 1'b1;
            lock_count_nxt = cfg.lockout;
          end
        end
        default: begin
          if (locked_r) begin
            if (lock_count_r <= htc_pkg::LOCK_W'(1)) begin
              locked_nxt     = 1'b0;
              lock_count_nxt = '0;
            end else begin
              lock_count_nxt = lock_count_r - htc_pkg::LOCK_W'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= htc_pkg::MODE_OFF;
      target_r     <= htc_pkg::DEFAULT_SET_POINT;
      locked_r     <= 1'b0;
      lock_count_r <= '0;
    end else begin
      mode_r       <= mode_nxt;
      target_r     <= target_nxt;
      locked_r     <= locked_nxt;
      lock_count_r <= lock_count_nxt;
    end
  end

  assign status_nxt.mode      = mode_nxt;
  assign status_nxt.set_point = target_nxt;

endmodule

### sv/hysteresis_thermostat_core.sv
// hysteresis thermostat core: input register, control step, result register
// path: a request passes the input register, then the result register
// throughput: one request per cycle, limited only by out_tready
// the input register takes a new request while the result register still holds one
// reset (rst_n low at a clock edge): registers to defaults, setpoint 20, mode off,
// lockout cleared, both pipeline stages empty
module hysteresis_thermostat_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [htc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [htc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] temperature
  input  logic [1:0]                        in_tuser,   // [1:0] func
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata   // [1:0] mode, [2] heater_on,
                                                        // [3] cooler_on, [11:4] set_point,
                                                        // [15:12] zero
);

  htc_pkg::cfg_t     cfg;
  htc_pkg::sp_load_t sp_load;
  htc_pkg::status_t  status_nxt;

  // input stage
  logic                              in_vld_r, in_vld_nxt;
  htc_pkg::func_t                    in_func_r;
  logic signed [htc_pkg::TEMP_W-1:0] in_temp_r;

  // result stage
  logic                              out_vld_r, out_vld_nxt;
  htc_pkg::status_t                  out_stat_r;

  logic in_acc;
  logic adv;      // result register can take the request in the input stage
  logic step_en;

  // registers are to be written only while idle (the block does not enforce this), so no back-pressure is needed
  assign cfg_ready = 1'b1;

  htc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .sp_load   (sp_load)
  );

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign step_en   = in_vld_r && adv;

  // state moves when the request leaves the input stage
  htc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .func        (in_func_r),
    .temperature (in_temp_r),
    .cfg         (cfg),
    .sp_load     (sp_load),
    .status_nxt  (status_nxt)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step_en) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_func_r <= htc_pkg::func_t'(in_tuser);
      in_temp_r <= $signed(in_tdata);
    end
    if (step_en) begin
      out_stat_r <= status_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000,
                       out_stat_r.set_point,
                       out_stat_r.mode == htc_pkg::MODE_COOL,
                       out_stat_r.mode == htc_pkg::MODE_HEAT,
                       out_stat_r.mode};

endmodule

### sv/htc_checker.sv
// port-level checks for the hysteresis thermostat core and their binding
module htc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // heater and cooler never drive together
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[3]))
    else $error("heater and cooler both on");

  // drives follow the reported mode
  a_drive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[1:0] == htc_pkg::MODE_HEAT)) &&
                   (out_tdata[3] == (out_tdata[1:0] == htc_pkg::MODE_COOL)))
    else $error("drive does not match mode");

  // an accepted request moves on into the result register when the result port is not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 (!out_tvalid || out_tready) |=> out_tvalid)
    else $error("request lost between stages");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind hysteresis_thermostat_core htc_checker u_htc_checker (.*);

### sim/hysteresis_thermostat_core_tb.sv
// self-checking testbench for the hysteresis thermostat core
module hysteresis_thermostat_core_tb;
  import htc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 260;
  localparam int NUM_PHASES   = 7;

  // result word as it leaves the block, lowest field in the lowest bits
  typedef struct packed {
    logic [3:0]               pad;
    logic signed [TEMP_W-1:0] set_point;
    logic                     cooler_on;
    logic                     heater_on;
    mode_t                    mode;
  } status_word_t;

  // one row of the directed table: a request or a register write
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t kind;
    func_t     func;
    int        value;    // temperature for a request, write data for a register
    reg_idx_t  idx;
    bit        typed;    // expected result given in the row
    mode_t     exp_mode;
    int        exp_sp;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_INIT_SP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;       // [7:0] temperature
  logic [1:0]            in_tuser = FUNC_SAMPLE; // [1:0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;          // [1:0] mode, [2] heater, [3] cooler, [11:4] set_point

  hysteresis_thermostat_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // thermostat state as the block should hold it
  mode_t                    pred_mode;
  logic signed [TEMP_W-1:0] pred_target;
  logic                     pred_locked;
  logic [LOCK_W-1:0]        pred_lock_left;
  // register copies
  logic signed [TEMP_W-1:0] reg_init_sp;
  logic [HYST_W-1:0]        reg_hyst;
  logic signed [TEMP_W-1:0] reg_min;
  logic signed [TEMP_W-1:0] reg_max;
  logic [LOCK_W-1:0]        reg_lockout;

  status_word_t expected_status_q[$];
  stim_row_t    directed_rows[$];

  // typed expectation travelling with the request currently offered
  bit           req_typed = 1'b0;
  status_word_t typed_status = '0;

  bit hold_request = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // setpoint reload: only a value strictly inside the limits is taken
  function automatic void reload_setpoint();
    if (reg_init_sp < reg_max && reg_init_sp > reg_min) begin
      pred_target = reg_init_sp;
    end else begin
      pred_target = DEFAULT_SET_POINT;
    end
  endfunction

  function automatic void reset_thermostat();
    reg_init_sp    = RST_INIT_SP;
    reg_hyst       = RST_HYST;
    reg_min        = RST_SET_MIN;
    reg_max        = RST_SET_MAX;
    reg_lockout    = RST_LOCKOUT;
    pred_mode      = MODE_OFF;
    pred_locked    = 1'b0;
    pred_lock_left = '0;
    reload_setpoint();
  endfunction

  function automatic void apply_register_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_INIT_SP: begin
        reg_init_sp = d[7:0];
        reload_setpoint();
      end
      REG_HYST:    reg_hyst = d[HYST_W-1:0];
      REG_SET_MIN: reg_min = d[7:0];
      REG_SET_MAX: reg_max = d[7:0];
      REG_LOCKOUT: reg_lockout = d[LOCK_W-1:0];
      default: ;
    endcase
  endfunction

  // advance the thermostat by one request and return the status it leaves
  function automatic status_word_t predict_status(func_t f, logic signed [TEMP_W-1:0] temp);
    int tv;
    int tg;
    int h;
    status_word_t s;
    tv = temp;
    tg = pred_target;
    h  = reg_hyst;
    case (f)
      FUNC_SAMPLE: begin
        case (pred_mode)
          MODE_OFF: begin
            if (tv < tg - h) pred_mode = MODE_HEAT;
            else if (tv > tg + h) pred_mode = MODE_COOL;
          end
          MODE_HEAT: if (tv >= tg) pred_mode = MODE_OFF;
          default:   if (tv <= tg) pred_mode = MODE_OFF;
        endcase
      end
      FUNC_UP, FUNC_DOWN: begin
        // a press while locked is dropped and does not restart the lockout
        if (!pred_locked) begin
          if (f == FUNC_UP && pred_target < reg_max) pred_target = pred_target + 8'sd1;
          if (f == FUNC_DOWN && pred_target > reg_min) pred_target = pred_target - 8'sd1;
          pred_locked    = 1'b1;
          pred_lock_left = reg_lockout;
        end
      end
      default: begin
        // a lockout of zero ends on the first tick, like a lockout of one
        if (pred_locked) begin
          if (pred_lock_left <= 16'd1) begin
            pred_locked    = 1'b0;
            pred_lock_left = '0;
          end else begin
            pred_lock_left = pred_lock_left - 16'd1;
          end
        end
      end
    endcase
    s.pad       = '0;
    s.set_point = pred_target;
    s.cooler_on = (pred_mode == MODE_COOL);
    s.heater_on = (pred_mode == MODE_HEAT);
    s.mode      = pred_mode;
    return s;
  endfunction

  function automatic stim_row_t req_row(func_t f, int temp);
    stim_row_t r;
    r = '{ROW_REQ, f, temp, REG_INIT_SP, 1'b0, MODE_OFF, 0};
    return r;
  endfunction

  function automatic stim_row_t chk_row(func_t f, int temp, mode_t m, int sp);
    stim_row_t r;
    r = '{ROW_REQ, f, temp, REG_INIT_SP, 1'b1, m, sp};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_t idx, int value);
    stim_row_t r;
    r = '{ROW_CFG, FUNC_SAMPLE, value, idx, 1'b0, MODE_OFF, 0};
    return r;
  endfunction

  // offer one request and hold it until accepted; tvalid stays high afterwards
  task automatic send_request(func_t f, int temp, bit typed, mode_t m, int sp);
    @(negedge clk);
    in_tvalid    = 1'b1;
    in_tuser     = f;
    in_tdata     = temp[7:0];
    req_typed    = typed;
    typed_status = {4'b0, sp[7:0], m == MODE_COOL, m == MODE_HEAT, m};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every outstanding result is back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    // leave some margin after the last result
    repeat (4) @(posedge clk);
  endtask

  // 8-bit registers get their value sign-extended across the data bus
  task automatic write_register(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // monitor: register writes and requests update the prediction, results are checked
  always @(posedge clk) begin : status_monitor
    status_word_t predicted;
    status_word_t exp_s;
    status_word_t got_s;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_register_write(reg_idx_t'(cfg_index), cfg_data);
      end
      if (in_tvalid && in_tready) begin
        predicted = predict_status(func_t'(in_tuser), $signed(in_tdata));
        expected_status_q.push_back(req_typed ? typed_status : predicted);
      end
      if (out_tvalid && out_tready) begin
        got_s = out_tdata;
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result exp none got %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          exp_s = expected_status_q.pop_front();
          if (got_s.mode !== exp_s.mode) begin
            $display("%0t: mode mismatch exp %0d got %0d", $time, exp_s.mode, got_s.mode);
            mismatch_count++;
          end
          if (got_s.heater_on !== exp_s.heater_on) begin
            $display("%0t: heater_on mismatch exp %b got %b", $time,
                     exp_s.heater_on, got_s.heater_on);
            mismatch_count++;
          end
          if (got_s.cooler_on !== exp_s.cooler_on) begin
            $display("%0t: cooler_on mismatch exp %b got %b", $time,
                     exp_s.cooler_on, got_s.cooler_on);
            mismatch_count++;
          end
          if (got_s.set_point !== exp_s.set_point) begin
            $display("%0t: set_point mismatch exp %0d got %0d", $time,
                     exp_s.set_point, got_s.set_point);
            mismatch_count++;
          end
          if (got_s.pad !== exp_s.pad) begin
            $display("%0t: padding mismatch exp %h got %h", $time, exp_s.pad, got_s.pad);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("hysteresis_thermostat_core regression: fail");
      $finish;
    end
  end

  // receiver: segments of random length, each with its own stall pattern,
  // plus one long hold-off on request so the pipeline backs up into the input
  initial begin : result_sink
    int style;
    int len;
    wait (rst_n === 1'b1);
    forever begin
      style = $urandom_range(0, 3);
      len   = $urandom_range(8, 64);
      for (int k = 0; k < len; k++) begin
        @(negedge clk);
        if (hold_request) begin
          out_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_request = 1'b0;
        end
        case (style)
          0:       out_tready = 1'b1;
          1:       out_tready = $urandom_range(0, 1);
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = k[0];
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int burst_len;
    int gap;
    int sent;
    int pick;
    int span;
    int tv;
    func_t f;

    reset_thermostat();

    // directed table, defaults after reset: setpoint 20, band 3, limits 5..35, lockout 50
    // band edges in off mode: 17 and 23 do not switch, 16 heats, 24 cools
    directed_rows.push_back(chk_row(FUNC_TICK,   0,    MODE_OFF,  20)); // tick while unlocked
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 17,   MODE_OFF,  20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 23,   MODE_OFF,  20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 16,   MODE_HEAT, 20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 19,   MODE_HEAT, 20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 20,   MODE_OFF,  20)); // heat stops at setpoint
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 24,   MODE_COOL, 20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 20,   MODE_OFF,  20)); // cool stops at setpoint
    directed_rows.push_back(chk_row(FUNC_SAMPLE, -128, MODE_HEAT, 20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 127,  MODE_OFF,  20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, 127,  MODE_COOL, 20));
    directed_rows.push_back(chk_row(FUNC_SAMPLE, -128, MODE_OFF,  20));
    // lockout of one tick; temperature is don't-care on buttons
    directed_rows.push_back(cfg_row(REG_LOCKOUT, 1));
    directed_rows.push_back(chk_row(FUNC_UP,     -1,   MODE_OFF,  21));
    directed_rows.push_back(chk_row(FUNC_UP,     0,    MODE_OFF,  21)); // press while locked
    directed_rows.push_back(chk_row(FUNC_DOWN,   0,    MODE_OFF,  21));
    directed_rows.push_back(chk_row(FUNC_TICK,   0,    MODE_OFF,  21));
    directed_rows.push_back(chk_row(FUNC_DOWN,   -128, MODE_OFF,  20));
    // zero lockout behaves as one tick
    directed_rows.push_back(cfg_row(REG_LOCKOUT, 0));
    directed_rows.push_back(chk_row(FUNC_TICK,   0,    MODE_OFF,  20));
    directed_rows.push_back(chk_row(FUNC_UP,     0,    MODE_OFF,  21));
    directed_rows.push_back(chk_row(FUNC_TICK,   0,    MODE_OFF,  21));
    directed_rows.push_back(chk_row(FUNC_UP,     0,    MODE_OFF,  22));
    // step at the upper limit, then the lower limit, then crossed limits
    directed_rows.push_back(cfg_row(REG_SET_MAX, 22));
    directed_rows.push_back(chk_row(FUNC_TICK,   0,    MODE_OFF,  22));
    directed_rows.push_back(chk_row(FUNC_UP,     0,    MODE_OFF,  22));
    directed_rows.push_back(cfg_row(REG_SET_MIN, 22));
    directed_rows.push_back(chk_row(FUNC_TICK,   0,    MODE_OFF,  22));
    directed_rows.push_back(chk_row(FUNC_DOWN,   0,    MODE_OFF,  22));
    directed_rows.push_back(cfg_row(REG_SET_MIN, 30));
    directed_rows.push_back(req_row(FUNC_TICK,   0));
    directed_rows.push_back(req_row(FUNC_UP,     0));
    // initial setpoint outside the limits falls back, inside is taken
    directed_rows.push_back(cfg_row(REG_INIT_SP, 127));
    directed_rows.push_back(req_row(FUNC_SAMPLE, 20));
    directed_rows.push_back(cfg_row(REG_SET_MIN, -128));
    directed_rows.push_back(cfg_row(REG_SET_MAX, 127));
    directed_rows.push_back(cfg_row(REG_INIT_SP, -127));
    // widest band around a setpoint near the bottom, then no band at all
    directed_rows.push_back(cfg_row(REG_HYST,    127));
    directed_rows.push_back(req_row(FUNC_SAMPLE, -128));
    directed_rows.push_back(req_row(FUNC_SAMPLE, 1));
    directed_rows.push_back(req_row(FUNC_SAMPLE, -127));
    directed_rows.push_back(cfg_row(REG_HYST,    0));
    directed_rows.push_back(req_row(FUNC_SAMPLE, -128));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_request(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                     directed_rows[i].exp_mode, directed_rows[i].exp_sp);
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_register(REG_SET_MIN, 5);
          write_register(REG_SET_MAX, 35);
          write_register(REG_INIT_SP, 20);
          write_register(REG_HYST, 3);
          write_register(REG_LOCKOUT, 2);
        end
        1: begin
          write_register(REG_SET_MIN, -128);
          write_register(REG_SET_MAX, 127);
          write_register(REG_INIT_SP, -100);
          write_register(REG_HYST, 0);
          write_register(REG_LOCKOUT, 1);
        end
        2: begin
          write_register(REG_INIT_SP, 127);
          write_register(REG_HYST, 127);
          write_register(REG_LOCKOUT, 0);
        end
        3: begin
          // narrow window, presses keep hitting both limits
          write_register(REG_SET_MIN, 10);
          write_register(REG_SET_MAX, 12);
          write_register(REG_INIT_SP, 11);
          write_register(REG_HYST, 2);
          write_register(REG_LOCKOUT, 3);
        end
        4: begin
          // crossed limits: no step possible, setpoint falls back
          write_register(REG_SET_MIN, 50);
          write_register(REG_SET_MAX, -50);
          write_register(REG_INIT_SP, -128);
          write_register(REG_HYST, 5);
          write_register(REG_LOCKOUT, 2);
        end
        5: begin
          write_register(REG_SET_MIN, int'($urandom_range(0, 255)) - 128);
          write_register(REG_SET_MAX, int'($urandom_range(0, 255)) - 128);
          write_register(REG_INIT_SP, int'($urandom_range(0, 255)) - 128);
          write_register(REG_HYST, $urandom_range(0, 127));
          write_register(REG_LOCKOUT, 65535);
        end
        default: begin
          write_register(REG_SET_MIN, int'($urandom_range(0, 120)) - 128);
          write_register(REG_SET_MAX, $urandom_range(0, 127));
          write_register(REG_INIT_SP, int'($urandom_range(0, 255)) - 128);
          write_register(REG_HYST, $urandom_range(0, 127));
          write_register(REG_LOCKOUT, $urandom_range(1, 8));
        end
      endcase

      sent = 0;
      // phase 1 opens with a long receiver hold-off under a gapless burst
      if (phase == 1) hold_request = 1'b1;
      while (sent < PHASE_ITEMS) begin
        burst_len = (phase == 1 && sent == 0) ? 60 : $urandom_range(1, 24);
        for (int b = 0; b < burst_len && sent < PHASE_ITEMS; b++) begin
          pick = $urandom_range(0, 99);
          tv   = $urandom_range(0, 255);
          if (pick < 50) begin
            f = FUNC_SAMPLE;
            // mostly close to the band edges, sometimes anywhere
            if ($urandom_range(0, 3) != 0) begin
              span = int'(reg_hyst) + 3;
              tv   = pred_target;
              tv   = tv + int'($urandom_range(0, 2 * span)) - span;
              if (tv > 127) tv = 127;
              if (tv < -128) tv = -128;
            end
          end else if (pick < 65) begin
            f = FUNC_UP;
          end else if (pick < 80) begin
            f = FUNC_DOWN;
          end else begin
            f = FUNC_TICK;
          end
          send_request(f, tv, 1'b0, MODE_OFF, 0);
          sent++;
          // once, let everything drain in the middle of a phase
          if (phase == 3 && sent == PHASE_ITEMS / 2) wait_idle();
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_tvalid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hysteresis_thermostat_core regression: pass");
    end else begin
      $display("hysteresis_thermostat_core regression: fail");
    end
    $finish;
  end

endmodule
